FILE: rtl/kmsp_pkg.sv
// kmsp_pkg: shared constants and types for the key matrix scan packer
// no dependencies; imported by key_matrix_scan_packer and kmsp_props
`default_nettype none

package kmsp_pkg;

  // fixed field widths of the ports
  localparam int COL_W    = 6;
  localparam int DRIVE_W  = 4;
  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 16;

  // frame packing
  localparam int          BITS_PER_BYTE = 7;
  localparam logic [7:0]  END_BYTE      = 8'h80;

  // configuration port
  localparam int          APB_DW       = 32;
  localparam int          APB_AW       = 3;
  localparam logic [15:0] SETTLE_RESET = 16'd100;
  localparam logic [15:0] PAUSE_RESET  = 16'd5000;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SETTLE = 1'b0,
    REG_PAUSE  = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/key_matrix_scan_packer.sv
// key_matrix_scan_packer: matrix row scanner with 7-bit key packing and framed output
// depends on kmsp_pkg
`default_nettype none

// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------------
// in        | in_valid / in_ready | column_levels[5:0]
// out       | out_valid/out_ready | row_drive[3:0] byte_valid tx_byte[7:0] frame_last
// cfg       | psel penable pwrite | paddr[2:0] pwdata[31:0] prdata[31:0] pready
//
// a tick is taken when in_valid meets in_ready; scan and pause ticks give one beat
// a frame tick gives DATA_BYTES+1 beats, one per cycle if not stalled, from the burst
// shift register, and holds in_ready low until the end byte is in the output register
// in_ready = !burst && (output register empty or being taken this cycle)
// rst is synchronous; counts, packed keys and flags clear, registers return to 100 / 5000
module key_matrix_scan_packer import kmsp_pkg::*; #(
  parameter int ROW_COUNT    = 4,
  parameter int COLUMN_COUNT = 6,
  parameter int USED_KEYS    = 21,
  parameter int DATA_BYTES   = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // tick input
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [COL_W-1:0]    column_levels,
  // result output
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DRIVE_W-1:0]       row_drive,
  output logic                     byte_valid,
  output logic [BYTE_W-1:0]        tx_byte,
  output logic                     frame_last,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int RW      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int FRAME_W = DATA_BYTES * BITS_PER_BYTE;
  localparam int BL_W    = $clog2(DATA_BYTES + 1);
  localparam logic [RW-1:0]   LAST_ROW   = RW'(ROW_COUNT - 1);
  localparam logic [BL_W-1:0] BURST_INIT = BL_W'(DATA_BYTES - 1);

  // configuration registers
  logic [TICK_W-1:0] settle_ticks;
  logic [TICK_W-1:0] pause_ticks;
  reg_idx_t          reg_sel;

  // scan state
  logic [RW-1:0]        row_index;
  logic                 in_pause;
  logic [TICK_W-1:0]    tick_count;
  logic [USED_KEYS-1:0] switch_bits;

  // frame burst
  logic                 burst;
  logic [BL_W-1:0]      burst_left;
  logic [FRAME_W-1:0]   frame_bits;

  // combinational terms
  logic                 in_fire;
  logic                 out_fire;
  logic [TICK_W-1:0]    tick_inc;
  logic                 settle_hit;
  logic                 pause_done;
  logic [USED_KEYS-1:0] key_set;
  logic [DRIVE_W-1:0]   drive;
  logic [FRAME_W-1:0]   frame_vec;
  logic [FRAME_W+USED_KEYS-1:0] sw_pad;

  // apb port, written on the access cycle
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_SETTLE: prdata = APB_DW'(settle_ticks);
      REG_PAUSE:  prdata = APB_DW'(pause_ticks);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= SETTLE_RESET;
      pause_ticks  <= PAUSE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SETTLE: settle_ticks <= pwdata[TICK_W-1:0];
        REG_PAUSE:  pause_ticks  <= pwdata[TICK_W-1:0];
        default:    ;
      endcase
    end
  end

  // handshakes
  assign out_fire = out_valid && out_ready;
  assign in_ready = !burst && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  // tick counting
  assign tick_inc   = tick_count + TICK_W'(1);
  assign settle_hit = (tick_inc >= settle_ticks);
  assign pause_done = (tick_inc >= pause_ticks);

  // one-hot drive, rows past the port width show nothing
  always_comb begin
    for (int i = 0; i < DRIVE_W; i++) begin
      drive[i] = (i < ROW_COUNT) && (int'(row_index) == i);
    end
  end

  // keys of the current row that read closed
  always_comb begin
    logic [COL_W-1:0] col_shift;
    for (int n = 0; n < USED_KEYS; n++) begin
      col_shift  = column_levels >> (n % COLUMN_COUNT);
      key_set[n] = ((n % COLUMN_COUNT) < COL_W)
                && (int'(row_index) == n / COLUMN_COUNT)
                && col_shift[0];
    end
  end

  // data bytes of the frame, keys beyond the used set read open
  assign sw_pad    = {{FRAME_W{1'b0}}, switch_bits};
  assign frame_vec = sw_pad[FRAME_W-1:0];

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= '0;
      in_pause    <= 1'b0;
      tick_count  <= '0;
      switch_bits <= '0;
    end else if (in_fire) begin
      if (!in_pause) begin
        if (settle_hit) begin
          tick_count  <= '0;
          switch_bits <= switch_bits | key_set;
          if (row_index == LAST_ROW) begin
            in_pause <= 1'b1;
          end else begin
            row_index <= row_index + RW'(1);
          end
        end else begin
          tick_count <= tick_inc;
        end
      end else if (!pause_done) begin
        tick_count <= tick_inc;
      end else begin
        tick_count  <= '0;
        switch_bits <= '0;
        in_pause    <= 1'b0;
        row_index   <= '0;
      end
    end
  end

  // output register and frame burst control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      burst      <= 1'b0;
      burst_left <= '0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
      if (in_pause && pause_done) begin
        burst      <= 1'b1;
        burst_left <= BURST_INIT;
      end
    end else if (out_fire && burst) begin
      if (burst_left != '0) begin
        burst_left <= burst_left - BL_W'(1);
      end else begin
        burst <= 1'b0;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!in_pause) begin
        row_drive  <= drive;
        byte_valid <= 1'b0;
        tx_byte    <= '0;
        frame_last <= 1'b0;
      end else if (!pause_done) begin
        row_drive  <= '0;
        byte_valid <= 1'b0;
        tx_byte    <= '0;
        frame_last <= 1'b0;
      end else begin
        row_drive  <= '0;
        byte_valid <= 1'b1;
        tx_byte    <= {1'b0, frame_vec[BITS_PER_BYTE-1:0]};
        frame_last <= 1'b0;
        frame_bits <= frame_vec >> BITS_PER_BYTE;
      end
    end else if (out_fire && burst) begin
      if (burst_left != '0) begin
        tx_byte    <= {1'b0, frame_bits[BITS_PER_BYTE-1:0]};
        frame_bits <= frame_bits >> BITS_PER_BYTE;
      end else begin
        tx_byte    <= END_BYTE;
        frame_last <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kmsp_checker.sv
// kmsp_props: port-level checks on the key matrix scan packer
// depends on kmsp_pkg; bound to key_matrix_scan_packer below
`default_nettype none

module kmsp_props import kmsp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [DRIVE_W-1:0] row_drive,
  input wire logic               byte_valid,
  input wire logic [BYTE_W-1:0]  tx_byte,
  input wire logic               frame_last
);

  // end byte is always a frame byte carrying the end code
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> byte_valid && (tx_byte == END_BYTE))
    else $error("frame_last without end byte");

  // frame bytes never drive a row, scan beats drive at most one
  a_drive_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(row_drive) && (!byte_valid || (row_drive == '0)))
    else $error("bad row drive");

  // a frame beat taken before its end byte is followed at once by the next frame beat
  a_burst_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && byte_valid && !frame_last |=> out_valid && byte_valid)
    else $error("frame burst broken");

  // no new tick while a frame is still going out
  a_burst_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid && !frame_last |-> !in_ready)
    else $error("tick taken during frame burst");

  // a stalled beat holds its byte
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(frame_last))
    else $error("stalled beat changed");

endmodule

bind key_matrix_scan_packer kmsp_props u_kmsp_props (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .row_drive  (row_drive),
  .byte_valid (byte_valid),
  .tx_byte    (tx_byte),
  .frame_last (frame_last)
);

`default_nettype wire
